### rtl/vtm_pkg.sv
`default_nettype none

package vtm_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int TIME_WIDTH_DEF = 32;

  localparam int OP_W    = 2;
  localparam int DELAY_W = 32;
  localparam int SID_W   = 3;
  localparam int KIND_W  = 2;
  localparam int TNOW_W  = 32;

  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_ONESHOT = 2'd1;
  localparam logic [OP_W-1:0] OP_REPEAT  = 2'd2;
  localparam logic [OP_W-1:0] OP_CANCEL  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_STARTED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CANCELLED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FIRE,
    S_REARM,
    S_FLUSH
  } state_t;

endpackage

`default_nettype wire

### rtl/vtm_if.sv
`default_nettype none

interface vtm_in_if import vtm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [DELAY_W-1:0] delay_us;
  logic [SID_W-1:0]   slot_id;

  modport source (output valid, output opcode, output delay_us, output slot_id, input ready);
  modport sink   (input valid, input opcode, input delay_us, input slot_id, output ready);
endinterface

interface vtm_out_if import vtm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SID_W-1:0]  timer_slot;
  logic [TNOW_W-1:0] time_now;
  logic              last;

  modport source (output valid, output kind, output timer_slot, output time_now,
                  output last, input ready);
  modport sink   (input valid, input kind, input timer_slot, input time_now,
                  input last, output ready);
endinterface

`default_nettype wire

### rtl/virtual_timer_multiplexer_top.sv
// Item flow: an accept state, an op state, then a scan pass that reads and checks each
// slot; per firing a fire state (plus a rearm state for a repeating timer) and another
// scan pass; then a flush state. Fire and flush wait while the output cannot take data.
// One item at a time; the scan over deadline memory runs through the shared adder.
// Reset (synchronous, rst_n low) zeroes the counter and frees all slots; the deadline
// and period memories are not cleared (an entry is only used after it has been written).
`default_nettype none

module virtual_timer_multiplexer_top import vtm_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  vtm_in_if.sink    in_chan,
  vtm_out_if.source out_chan
);

  localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TW     = TIME_WIDTH;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_TIMERS - 1);

  state_t state_r, state_nxt;

  logic [TW-1:0]         now_r, now_nxt;
  logic [NUM_TIMERS-1:0] active_r, active_nxt;
  logic [NUM_TIMERS-1:0] rep_r, rep_nxt;
  logic [NUM_TIMERS-1:0] pend_r, pend_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic [SLOT_W-1:0]     best_r, best_nxt;
  logic [TW-1:0]         best_age_r, best_age_nxt;
  logic                  best_vld_r, best_vld_nxt;
  logic                  first_r, first_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [TW-1:0]         dly_r, dly_nxt;
  logic [SID_W-1:0]      sid_r, sid_nxt;

  logic                  hold_vld_r, hold_vld_nxt;
  logic [KIND_W-1:0]     hold_kind_r, hold_kind_nxt;
  logic [SID_W-1:0]      hold_slot_r, hold_slot_nxt;

  logic                  out_vld_r, out_vld_nxt;
  logic [KIND_W-1:0]     out_kind_r, out_kind_nxt;
  logic [SID_W-1:0]      out_slot_r, out_slot_nxt;
  logic [TNOW_W-1:0]     out_time_r, out_time_nxt;
  logic                  out_last_r, out_last_nxt;

  // shared unit
  logic [TW-1:0] alu_a, alu_b, alu_res;
  logic          alu_sub;

  // memories
  logic              dl_we;
  logic [SLOT_W-1:0] dl_waddr;
  logic [TW-1:0]     dl_wdata, dl_rdata;
  logic              pr_we;
  logic [TW-1:0]     pr_rdata;

  logic              free_vld;
  logic [SLOT_W-1:0] free_idx;
  logic              is_rep;
  logic [TW-1:0]     per_eff;
  logic              sid_ok;
  logic [SLOT_W-1:0] sid_idx;
  logic              out_free;
  logic              can_emit;
  logic              push;
  logic              push_last;
  logic              cand;
  logic              take;

  vtm_alu #(.WIDTH(TW)) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res)
  );

  vtm_ram #(.WIDTH(TW), .DEPTH(NUM_TIMERS)) u_deadline_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (idx_r),
    .rdata (dl_rdata)
  );

  vtm_ram #(.WIDTH(TW), .DEPTH(NUM_TIMERS)) u_period_ram (
    .clk   (clk),
    .we    (pr_we),
    .waddr (free_idx),
    .wdata (per_eff),
    .raddr (best_r),
    .rdata (pr_rdata)
  );

  // lowest free slot
  always_comb begin
    free_vld = 1'b0;
    free_idx = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_vld = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign is_rep   = (op_r == OP_REPEAT);
  assign per_eff  = (is_rep && dly_r == '0) ? TW'(1) : dly_r;
  assign sid_idx  = SLOT_W'(sid_r);
  assign sid_ok   = (int'(sid_r) < NUM_TIMERS) && active_r[sid_idx];
  assign out_free = !out_vld_r || out_chan.ready;
  // a new result may be made once the held one has somewhere to go
  assign can_emit = !hold_vld_r || out_free;

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = out_vld_r;
  assign out_chan.kind       = out_kind_r;
  assign out_chan.timer_slot = out_slot_r;
  assign out_chan.time_now   = out_time_r;
  assign out_chan.last       = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    active_nxt    = active_r;
    rep_nxt       = rep_r;
    pend_nxt      = pend_r;
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    best_age_nxt  = best_age_r;
    best_vld_nxt  = best_vld_r;
    first_nxt     = first_r;
    op_nxt        = op_r;
    dly_nxt       = dly_r;
    sid_nxt       = sid_r;
    hold_vld_nxt  = hold_vld_r;
    hold_kind_nxt = hold_kind_r;
    hold_slot_nxt = hold_slot_r;
    alu_a         = now_r;
    alu_b         = per_eff;
    alu_sub       = 1'b0;
    dl_we         = 1'b0;
    dl_waddr      = free_idx;
    dl_wdata      = alu_res;
    pr_we         = 1'b0;
    push          = 1'b0;
    push_last     = 1'b0;
    cand          = 1'b0;
    take          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt    = in_chan.opcode;
          dly_nxt   = TW'(in_chan.delay_us);
          sid_nxt   = in_chan.slot_id;
          state_nxt = S_OP;
        end
      end

      S_OP: begin
        unique case (op_r)
          OP_TICK: begin
            alu_b   = TW'(1);
            now_nxt = alu_res;
          end
          OP_ONESHOT, OP_REPEAT: begin
            hold_vld_nxt = 1'b1;
            if (free_vld) begin
              active_nxt[free_idx] = 1'b1;
              rep_nxt[free_idx]    = is_rep;
              dl_we                = 1'b1;
              pr_we                = 1'b1;
              hold_kind_nxt        = KIND_STARTED;
              hold_slot_nxt        = SID_W'(free_idx);
            end else begin
              hold_kind_nxt = KIND_ERROR;
              hold_slot_nxt = '0;
            end
          end
          OP_CANCEL: begin
            hold_vld_nxt  = 1'b1;
            hold_slot_nxt = sid_r;
            if (sid_ok) begin
              active_nxt[sid_idx] = 1'b0;
              rep_nxt[sid_idx]    = 1'b0;
              hold_kind_nxt       = KIND_CANCELLED;
            end else begin
              hold_kind_nxt = KIND_ERROR;
            end
          end
          default: ;
        endcase
        idx_nxt      = '0;
        first_nxt    = 1'b1;
        best_vld_nxt = 1'b0;
        state_nxt    = S_SCAN_RD;
      end

      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        // age = now - deadline; passed when the top bit is clear
        alu_b   = dl_rdata;
        alu_sub = 1'b1;
        if (first_r) begin
          cand              = active_r[idx_r] && !alu_res[TW-1];
          pend_nxt[idx_r]   = cand;
        end else begin
          cand = pend_r[idx_r];
        end
        take = cand && (!best_vld_r || alu_res > best_age_r);
        if (take) begin
          best_nxt     = idx_r;
          best_age_nxt = alu_res;
          best_vld_nxt = 1'b1;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = (best_vld_r || take) ? S_FIRE : S_FLUSH;
        end else begin
          idx_nxt   = idx_r + SLOT_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end

      S_FIRE: begin
        if (can_emit) begin
          push             = hold_vld_r;
          hold_vld_nxt     = 1'b1;
          hold_kind_nxt    = KIND_FIRED;
          hold_slot_nxt    = SID_W'(best_r);
          pend_nxt[best_r] = 1'b0;
          if (rep_r[best_r]) begin
            state_nxt = S_REARM;
          end else begin
            active_nxt[best_r] = 1'b0;
            idx_nxt            = '0;
            first_nxt          = 1'b0;
            best_vld_nxt       = 1'b0;
            state_nxt          = S_SCAN_RD;
          end
        end
      end

      S_REARM: begin
        // period memory was addressed by best_r during the fire cycle
        alu_b        = pr_rdata;
        dl_we        = 1'b1;
        dl_waddr     = best_r;
        idx_nxt      = '0;
        first_nxt    = 1'b0;
        best_vld_nxt = 1'b0;
        state_nxt    = S_SCAN_RD;
      end

      S_FLUSH: begin
        if (!hold_vld_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push         = 1'b1;
          push_last    = 1'b1;
          hold_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_kind_nxt = out_kind_r;
    out_slot_nxt = out_slot_r;
    out_time_nxt = out_time_r;
    out_last_nxt = out_last_r;
    if (push) begin
      out_vld_nxt  = 1'b1;
      out_kind_nxt = hold_kind_r;
      out_slot_nxt = hold_slot_r;
      out_time_nxt = TNOW_W'(now_r);
      out_last_nxt = push_last;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      now_r      <= '0;
      active_r   <= '0;
      rep_r      <= '0;
      pend_r     <= '0;
      best_vld_r <= 1'b0;
      first_r    <= 1'b0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      now_r      <= now_nxt;
      active_r   <= active_nxt;
      rep_r      <= rep_nxt;
      pend_r     <= pend_nxt;
      best_vld_r <= best_vld_nxt;
      first_r    <= first_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    best_r      <= best_nxt;
    best_age_r  <= best_age_nxt;
    op_r        <= op_nxt;
    dly_r       <= dly_nxt;
    sid_r       <= sid_nxt;
    hold_kind_r <= hold_kind_nxt;
    hold_slot_r <= hold_slot_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_time_r  <= out_time_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

`default_nettype wire

### rtl/vtm_ram.sv
`default_nettype none

module vtm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/vtm_alu.sv
`default_nettype none

// Shared add/subtract unit: counter advance, deadline arming and age computation.
module vtm_alu #(
  parameter int WIDTH = 32
) (
  input  wire logic [WIDTH-1:0] a_i,
  input  wire logic [WIDTH-1:0] b_i,
  input  wire logic             sub_i,
  output logic      [WIDTH-1:0] res_o
);

  always_comb begin
    if (sub_i) begin
      res_o = a_i - b_i;
    end else begin
      res_o = a_i + b_i;
    end
  end

endmodule

`default_nettype wire
